// ----- src/region_access_lock_table_defines.svh -----
// assertion macros for the region access lock table
// used by region_access_lock_table.sv; expects i_clk and i_rst_n in scope
`ifndef REGION_ACCESS_LOCK_TABLE_DEFINES_SVH
`define REGION_ACCESS_LOCK_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RALT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("region lock table check failed");

// next-cycle implication, checked outside reset
`define RALT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("region lock table sequencing check failed");

`endif

// ----- src/ralt_pkg.sv -----
// shared types, codes and defaults for the region access lock table
// no dependencies
`default_nettype none

package ralt_pkg;

    localparam int NUM_REGIONS_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int REGION_W    = 10;
    localparam int REGION_SPAN = 1 << REGION_W;
    localparam int RCOUNT_W    = 11;

    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_LOCK  = 2'd2;
    localparam logic [1:0] CMD_ALLOC = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RETRY      = 2'd1;
    localparam logic [1:0] ST_NO_FREE    = 2'd2;
    localparam logic [1:0] ST_CLOSE_ZERO = 2'd3;

    // bit positions in the per-region flag field
    localparam int FLAG_LOCK = 0;
    localparam int FLAG_BR   = 1;
    localparam int FLAG_BW   = 2;

    typedef struct packed {
        logic [1:0]          command;
        logic [REGION_W-1:0] region;
        logic                mode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [REGION_W-1:0] allocated_region;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic                need_mem;
        logic [1:0]          command;
        logic [REGION_W-1:0] region;
        logic                mode;
        t_out_item           result;
    } t_work;

    typedef struct packed {
        logic mid_pop;
        logic res_push;
        logic clearing;
    } t_back_ctl;

endpackage

`default_nettype wire

// ----- src/ralt_fifo.sv -----
// small register queue used between front and back and on the result side
// no package dependency
`default_nettype none

module ralt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_cnt = r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/ralt_front.sv -----
// front end: takes commands, range-checks them and serves allocate from the free count
// depends on ralt_pkg
`default_nettype none

module ralt_front #(
    parameter int NUM_REGIONS = ralt_pkg::NUM_REGIONS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ralt_pkg::RCOUNT_W-1:0] i_cfg_wdata,
    input  wire logic                        i_push,
    input  wire ralt_pkg::t_in_item          i_item,
    input  wire logic                        i_clearing,
    input  wire logic                        i_mid_full,
    output logic                             o_full,
    output logic                             o_mid_push,
    output ralt_pkg::t_work                  o_mid_item
);

    import ralt_pkg::*;

    localparam logic [RCOUNT_W-1:0] RESET_COUNT =
        (NUM_REGIONS < REGION_SPAN) ? RCOUNT_W'(NUM_REGIONS) : RCOUNT_W'(REGION_SPAN);

    logic [RCOUNT_W-1:0] r_region_count, n_region_count;
    logic [RCOUNT_W-1:0] r_free, n_free;
    logic [RCOUNT_W-1:0] cfg_limited;
    logic [RCOUNT_W-1:0] alloc_diff;
    logic                can_alloc;
    logic                accept;

    assign o_full     = i_mid_full || i_clearing;
    assign accept     = i_push && !o_full;
    assign o_mid_push = accept;

    // values beyond the table size are clipped
    assign cfg_limited = (32'(i_cfg_wdata) > NUM_REGIONS) ? RCOUNT_W'(NUM_REGIONS)
                                                         : i_cfg_wdata;
    assign can_alloc   = (r_free != '0) && (r_free <= r_region_count);
    assign alloc_diff  = r_region_count - r_free;

    always_comb begin
        o_mid_item                         = '0;
        o_mid_item.command                 = i_item.command;
        o_mid_item.mode                    = i_item.mode;
        o_mid_item.result.status           = ST_OK;
        o_mid_item.result.allocated_region = '0;
        n_free                             = r_free;
        n_region_count                     = r_region_count;
        priority if (i_item.command == CMD_ALLOC) begin
            if (can_alloc) begin
                o_mid_item.result.allocated_region = alloc_diff[REGION_W-1:0];
                if (accept) begin
                    n_free = r_free - 1'b1;
                end
            end else begin
                o_mid_item.result.status = ST_NO_FREE;
            end
        end else if (32'(i_item.region) >= NUM_REGIONS) begin
            o_mid_item.result.status = ST_RETRY;
        end else begin
            o_mid_item.need_mem = 1'b1;
            o_mid_item.region   = i_item.region;
        end
        if (i_cfg_we) begin
            n_region_count = cfg_limited;
            n_free         = cfg_limited;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= RESET_COUNT;
            r_free         <= RESET_COUNT;
        end else begin
            r_region_count <= n_region_count;
            r_free         <= n_free;
        end
    end

endmodule

`default_nettype wire

// ----- src/ralt_back.sv -----
// back end: clears the region table after reset, then runs one read-modify-write per table command
// depends on ralt_pkg
`default_nettype none

module ralt_back #(
    parameter int NUM_REGIONS = ralt_pkg::NUM_REGIONS_DEF,
    parameter int COUNT_WIDTH = ralt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_mid_empty,
    input  wire ralt_pkg::t_work i_mid_item,
    input  wire logic            i_res_full,
    output ralt_pkg::t_back_ctl  o_ctl,
    output ralt_pkg::t_out_item  o_res_item
);

    import ralt_pkg::*;

    localparam int MEM_DEPTH = (NUM_REGIONS < REGION_SPAN) ? NUM_REGIONS : REGION_SPAN;
    localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CW        = COUNT_WIDTH;
    localparam int ENTRY_W   = 3 + 2 * CW;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    t_work              r_work;
    logic [ENTRY_W-1:0] r_table [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               start;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [2:0]         flags, flags_n;
    logic [CW-1:0]      rcnt, rcnt_n, wcnt, wcnt_n;
    t_out_item          res;

    assign start = (r_state == S_IDLE) && !i_mid_empty && !i_res_full;

    assign flags = r_rd_data[ENTRY_W-1 -: 3];
    assign rcnt  = r_rd_data[2*CW-1 -: CW];
    assign wcnt  = r_rd_data[CW-1:0];

    always_comb begin
        flags_n = flags;
        rcnt_n  = rcnt;
        wcnt_n  = wcnt;
        res     = r_work.result;
        if (r_work.need_mem) begin
            res.status           = ST_OK;
            res.allocated_region = '0;
            unique case (r_work.command)
                CMD_OPEN: begin
                    if (flags[FLAG_LOCK]) begin
                        res.status = ST_RETRY;
                    end else if (r_work.mode) begin
                        if (flags[FLAG_BW] || wcnt == COUNT_MAX) begin
                            res.status = ST_RETRY;
                        end else begin
                            wcnt_n = wcnt + 1'b1;
                        end
                    end else begin
                        if (flags[FLAG_BR] || rcnt == COUNT_MAX) begin
                            res.status = ST_RETRY;
                        end else begin
                            rcnt_n = rcnt + 1'b1;
                        end
                    end
                end
                CMD_CLOSE: begin
                    if (r_work.mode) begin
                        if (wcnt == '0) begin
                            res.status = ST_CLOSE_ZERO;
                        end else begin
                            wcnt_n = wcnt - 1'b1;
                        end
                    end else begin
                        if (rcnt == '0) begin
                            res.status = ST_CLOSE_ZERO;
                        end else begin
                            rcnt_n = rcnt - 1'b1;
                        end
                    end
                end
                CMD_LOCK: begin
                    if (flags[FLAG_LOCK]) begin
                        res.status = ST_RETRY;
                    end else if (!r_work.mode && wcnt != '0) begin
                        flags_n[FLAG_BW] = 1'b1;
                        res.status       = ST_RETRY;
                    end else if (r_work.mode && (wcnt != '0 || rcnt != '0)) begin
                        flags_n[FLAG_BW] = 1'b1;
                        flags_n[FLAG_BR] = 1'b1;
                        res.status       = ST_RETRY;
                    end else begin
                        flags_n[FLAG_LOCK] = 1'b1;
                    end
                end
                default: begin
                    // allocate never needs the table
                    res.status = ST_RETRY;
                end
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        mem_we    = 1'b0;
        mem_waddr = r_work.region[IDX_W-1:0];
        mem_wdata = {flags_n, rcnt_n, wcnt_n};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                mem_we  = r_work.need_mem;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_ctl.mid_pop  = start;
    assign o_ctl.res_push = (r_state == S_EXEC);
    assign o_ctl.clearing = (r_state == S_CLEAR);
    assign o_res_item     = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_work <= i_mid_item;
        end
    end

    // single table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        if (start) begin
            r_rd_data <= r_table[i_mid_item.region[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- src/region_access_lock_table.sv -----
// top level of the region access lock table: front, command queue, back, result queue
// depends on ralt_pkg, ralt_fifo, ralt_front, ralt_back and the assertion macro header
`default_nettype none
`include "region_access_lock_table_defines.svh"

// In the back end each command first reads its region entry from the single table memory
// and then updates it and queues the result; a new command is taken only once the last
// one's result is queued and the result queue has room. Allocate and out-of-range
// commands take the same path. A two-entry queue on each side lets commands be taken while
// results wait to be popped. After reset the table is swept to zero, one entry per cycle,
// over min(NUM_REGIONS, 1024) entries; full stays high during the sweep, while configuration
// writes are taken as usual. Write the region count only while the block is idle.
module region_access_lock_table #(
    parameter int NUM_REGIONS = ralt_pkg::NUM_REGIONS_DEF,
    parameter int COUNT_WIDTH = ralt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    input  wire ralt_pkg::t_in_item            i_item,
    output logic                               full,
    input  wire logic                          pop,
    output ralt_pkg::t_out_item                o_result,
    output logic                               empty,
    input  wire logic                          i_cfg_we,
    input  wire logic [ralt_pkg::RCOUNT_W-1:0] i_cfg_wdata
);

    import ralt_pkg::*;

    logic      mid_push, mid_full, mid_empty, res_full;
    t_work     mid_wdata, mid_rdata;
    t_back_ctl back_ctl;
    t_out_item res_item;

    ralt_front #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_clearing  (back_ctl.clearing),
        .i_mid_full  (mid_full),
        .o_full      (full),
        .o_mid_push  (mid_push),
        .o_mid_item  (mid_wdata)
    );

    ralt_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (back_ctl.mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    ralt_back #(
        .NUM_REGIONS (NUM_REGIONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_rdata),
        .i_res_full  (res_full),
        .o_ctl       (back_ctl),
        .o_res_item  (res_item)
    );

    ralt_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_ctl.res_push),
        .i_wdata (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

    // the table sweep must keep commands out
    `RALT_ASSERT_IMP(a_full_while_clearing, back_ctl.clearing, full)
    // a back-end result always finds room in the result queue
    `RALT_ASSERT_IMP(a_res_no_overflow, back_ctl.res_push, !res_full)
    // every command taken by the back end yields its result in the next cycle
    `RALT_ASSERT_NEXT(a_pop_then_result, back_ctl.mid_pop, back_ctl.res_push)
    // no new command starts while one is being updated
    `RALT_ASSERT_IMP(a_one_in_flight, back_ctl.res_push, !back_ctl.mid_pop)

endmodule

`default_nettype wire

// ----- bench/region_access_lock_table_tb.sv -----
// testbench for the region access lock table: directed and random command streams
// checked against a behavioral copy of the table; depends on ralt_pkg and the block
`default_nettype none

module region_access_lock_table_tb;
    import ralt_pkg::*;

    localparam int          TABLE_SIZE = NUM_REGIONS_DEF;
    localparam logic [15:0] COUNT_TOP  = 16'hFFFF;
    localparam int          CYCLE_CAP  = 1_500_000;
    localparam int          SETTLE     = 6;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    t_in_item            i_item      = '0;
    logic                full;
    logic                pop         = 1'b0;
    t_out_item           o_result;
    logic                empty;
    logic                i_cfg_we    = 1'b0;
    logic [RCOUNT_W-1:0] i_cfg_wdata = '0;

    region_access_lock_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .pop         (pop),
        .o_result    (o_result),
        .empty       (empty),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the table
    logic [2:0]          shadow_flags   [TABLE_SIZE];
    logic [15:0]         shadow_readers [TABLE_SIZE];
    logic [15:0]         shadow_writers [TABLE_SIZE];
    logic [RCOUNT_W-1:0] shadow_total;
    logic [RCOUNT_W-1:0] shadow_free;

    t_out_item pending_results[$];
    int        error_count   = 0;
    int        items_sent    = 0;
    int        results_seen  = 0;
    int        cycle_count   = 0;
    int        burst_left    = 0;
    bit        push_on       = 1'b0;
    bit        sender_steady = 1'b0;
    bit        drain_always  = 1'b0;
    bit        rx_on         = 1'b0;
    int        rx_left       = 0;
    logic [9:0] region_pool[16];

    task automatic model_reset();
        for (int k = 0; k < TABLE_SIZE; k++) begin
            shadow_flags[k]   = '0;
            shadow_readers[k] = '0;
            shadow_writers[k] = '0;
        end
        shadow_total = RCOUNT_W'(TABLE_SIZE);
        shadow_free  = shadow_total;
    endtask

    task automatic model_region_count(input logic [RCOUNT_W-1:0] value);
        shadow_total = (value > RCOUNT_W'(TABLE_SIZE)) ? RCOUNT_W'(TABLE_SIZE) : value;
        shadow_free  = shadow_total;
    endtask

    task automatic model_command(input t_in_item it, output t_out_item res);
        logic [2:0]          f;
        logic [RCOUNT_W-1:0] handed;
        int                  r;
        r = int'(it.region);
        res.status = ST_OK;
        res.allocated_region = '0;
        if (it.command == CMD_ALLOC) begin
            if (shadow_free > 0 && shadow_free <= shadow_total) begin
                handed = shadow_total - shadow_free;
                res.allocated_region = handed[REGION_W-1:0];
                shadow_free--;
            end else begin
                res.status = ST_NO_FREE;
            end
        end else if (r >= TABLE_SIZE) begin
            res.status = ST_RETRY;
        end else begin
            f = shadow_flags[r];
            case (it.command)
                CMD_OPEN: begin
                    if (f[FLAG_LOCK]) begin
                        res.status = ST_RETRY;
                    end else if (it.mode) begin
                        if (f[FLAG_BW] || shadow_writers[r] == COUNT_TOP) res.status = ST_RETRY;
                        else shadow_writers[r]++;
                    end else begin
                        if (f[FLAG_BR] || shadow_readers[r] == COUNT_TOP) res.status = ST_RETRY;
                        else shadow_readers[r]++;
                    end
                end
                CMD_CLOSE: begin
                    if (it.mode) begin
                        if (shadow_writers[r] == 0) res.status = ST_CLOSE_ZERO;
                        else shadow_writers[r]--;
                    end else begin
                        if (shadow_readers[r] == 0) res.status = ST_CLOSE_ZERO;
                        else shadow_readers[r]--;
                    end
                end
                default: begin
                    if (f[FLAG_LOCK]) begin
                        res.status = ST_RETRY;
                    end else if (!it.mode && shadow_writers[r] != 0) begin
                        shadow_flags[r][FLAG_BW] = 1'b1;
                        res.status = ST_RETRY;
                    end else if (it.mode && (shadow_writers[r] != 0 || shadow_readers[r] != 0)) begin
                        shadow_flags[r][FLAG_BW] = 1'b1;
                        shadow_flags[r][FLAG_BR] = 1'b1;
                        res.status = ST_RETRY;
                    end else begin
                        shadow_flags[r][FLAG_LOCK] = 1'b1;
                    end
                end
            endcase
        end
    endtask

    task automatic sender_idle();
        if (push_on) begin
            push <= 1'b0;
            push_on = 1'b0;
        end
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [9:0] region,
                                input logic mode);
        t_in_item  it;
        t_out_item res;
        it.command = cmd;
        it.region  = region;
        it.mode    = mode;
        if (!sender_steady && burst_left == 0) begin
            sender_idle();
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        push    <= 1'b1;
        push_on = 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (full);
        model_command(it, res);
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_region_count(input logic [RCOUNT_W-1:0] value);
        sender_idle();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_region_count(value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: alternating runs of pops and stalls, or constant pops while drain_always is set
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_on   = !rx_on;
            rx_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        rx_left--;
        pop <= drain_always || rx_on;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual status %0d region %0d",
                         $time, o_result.status, o_result.allocated_region);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    error_count++;
                end
                if (o_result.allocated_region !== want.allocated_region) begin
                    $display("%0t: allocated_region mismatch, expected %0d actual %0d",
                             $time, want.allocated_region, o_result.allocated_region);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_allocation();
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        send_command(CMD_ALLOC, 10'd0, 1'b1);
        write_region_count(11'd0);
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        write_region_count(11'd1);
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        write_region_count(11'h7FF);
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        send_command(CMD_ALLOC, 10'd0, 1'b0);
        write_region_count(11'd1024);
    endtask

    task automatic test_access_rules();
        send_command(CMD_OPEN,  10'd0, 1'b0);
        send_command(CMD_OPEN,  10'd0, 1'b1);
        send_command(CMD_CLOSE, 10'd0, 1'b0);
        send_command(CMD_CLOSE, 10'd0, 1'b1);
        send_command(CMD_CLOSE, 10'd0, 1'b0);
        // shared lock taken with a reader still inside
        send_command(CMD_OPEN,  10'd1023, 1'b0);
        send_command(CMD_LOCK,  10'd1023, 1'b0);
        send_command(CMD_OPEN,  10'd1023, 1'b0);
        send_command(CMD_CLOSE, 10'd1023, 1'b0);
        send_command(CMD_LOCK,  10'd1023, 1'b1);
        // writer present: block writers, then block both, then lock
        send_command(CMD_OPEN,  10'd5, 1'b1);
        send_command(CMD_LOCK,  10'd5, 1'b0);
        send_command(CMD_OPEN,  10'd5, 1'b1);
        send_command(CMD_OPEN,  10'd5, 1'b0);
        send_command(CMD_CLOSE, 10'd5, 1'b1);
        send_command(CMD_LOCK,  10'd5, 1'b1);
        send_command(CMD_OPEN,  10'd5, 1'b0);
        send_command(CMD_CLOSE, 10'd5, 1'b0);
        send_command(CMD_LOCK,  10'd5, 1'b1);
        send_command(CMD_CLOSE, 10'd5, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [RCOUNT_W-1:0] phase_count[6];
        logic [1:0]          cmd;
        logic [9:0]          region;
        int                  pick;
        phase_count[0] = RCOUNT_W'($urandom_range(2, 30));
        phase_count[1] = 11'd0;
        phase_count[2] = 11'd1;
        phase_count[3] = 11'd1024;
        phase_count[4] = 11'h7FF;
        phase_count[5] = RCOUNT_W'($urandom_range(1025, 2046));
        for (int k = 0; k < 16; k++) region_pool[k] = 10'($urandom_range(0, 1023));
        for (int p = 0; p < 6; p++) begin
            write_region_count(phase_count[p]);
            sender_steady = (p == 3);
            drain_always  = (p == 3);
            for (int n = 0; n < 85; n++) begin
                if (n == 40) begin
                    sender_idle();
                    wait_drained();
                end
                pick   = $urandom_range(0, 99);
                cmd    = pick < 45 ? CMD_OPEN : pick < 80 ? CMD_CLOSE :
                         pick < 86 ? CMD_LOCK : CMD_ALLOC;
                region = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                     : region_pool[$urandom_range(0, 15)];
                send_command(cmd, region, 1'($urandom_range(0, 1)));
            end
        end
        sender_steady = 1'b0;
        drain_always  = 1'b0;
        sender_idle();
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_allocation();
        test_access_rules();
        test_random_traffic();
        sender_idle();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered allocation limits, lock and block rules, random mixes");
        $display("%0d commands sent, %0d results checked, %0d errors",
                 items_sent, results_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/ralt_pkg.sv
src/ralt_fifo.sv
src/ralt_front.sv
src/ralt_back.sv
src/region_access_lock_table.sv
bench/region_access_lock_table_tb.sv
